// ----- hdl/ptd_pkg.sv -----
// Shared types and constants for the priority task dispatcher.
// No dependencies; the dispatcher and the checker refer to it by scoped names.

package ptd_pkg;

    // Command codes carried in the operation field.
    typedef enum logic [1:0] {
        OP_CREATE   = 2'd0,
        OP_WAIT     = 2'd1,
        OP_START    = 2'd2,
        OP_SCHEDULE = 2'd3
    } t_op;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_NONE = 2'd2
    } t_status;

    localparam int unsigned PRIO_W   = 8;
    localparam int unsigned ID_W     = 8;
    localparam int unsigned DSLOT_W  = 3;

    localparam logic [PRIO_W-1:0] CEILING_RESET = 8'd50;

    // Sequencer states, one-hot.
    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } t_state;

    // One result beat as held in the output register.
    typedef struct packed {
        t_status             status;
        logic                dispatch_valid;
        logic [DSLOT_W-1:0]  dispatch_slot;
        logic [ID_W-1:0]     dispatch_task_id;
    } t_result;

endpackage

// ----- hdl/ptd_if.sv -----
// Valid/ready channel interfaces for the dispatcher: command beats in, result beats out.
// Depends on nothing; field widths follow the command and result formats.

interface ptd_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] priority_req;
    logic [7:0] task_id;

    modport source (output valid, output operation, output priority_req, output task_id,
                    input ready);
    modport sink   (input valid, input operation, input priority_req, input task_id,
                    output ready);
endinterface

interface ptd_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic       dispatch_valid;
    logic [2:0] dispatch_slot;
    logic [7:0] dispatch_task_id;

    modport source (output valid, output status, output dispatch_valid,
                    output dispatch_slot, output dispatch_task_id, input ready);
    modport sink   (input valid, input status, input dispatch_valid,
                    input dispatch_slot, input dispatch_task_id, output ready);
endinterface

// ----- hdl/ptd_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; width and depth are parameters.

module ptd_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 8
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/priority_task_dispatcher.sv -----
// A create beat goes from acceptance to the finish state and on into the result register;
// wait, start and schedule beats first scan the table, with one table read per cycle, the
// compare of the last entry and the result decision, and then the result load.
// The load waits while the result register is still full and its beat is not taken.
// One command is handled at a time; the port reopens after the load.
// Reset (i_rst_n, synchronous, active low) empties the table, clears ready flags and
// sets the running slot to 0 and the priority ceiling to 50.

module priority_task_dispatcher #(
    parameter int unsigned MAX_TASKS = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_wr_en,
    input  logic [7:0]      i_cfg_wr_data,
    ptd_cmd_if.sink         i_cmd,
    ptd_res_if.source       o_res
);

    localparam int unsigned IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_TASKS + 1);
    localparam int unsigned ENT_W = ptd_pkg::PRIO_W + ptd_pkg::ID_W;

    // Control state.
    ptd_pkg::t_state              r_state,   n_state;
    logic [ptd_pkg::PRIO_W-1:0]   r_ceiling, n_ceiling;
    logic [MAX_TASKS-1:0]         r_ready,   n_ready;
    logic [CNT_W-1:0]             r_used,    n_used;
    logic [IDX_W-1:0]             r_running, n_running;
    logic                         r_out_valid, n_out_valid;

    // Scan state. The scan issues one table read per cycle and compares the entry
    // returned by the previous read, so issue and compare overlap.
    logic [CNT_W-1:0]             r_iss,      n_iss;
    logic                         r_pend,     n_pend;
    logic [IDX_W-1:0]             r_pend_idx, n_pend_idx;
    logic                         r_is_start, n_is_start;
    logic [ptd_pkg::ID_W-1:0]     r_tid,      n_tid;
    logic [ptd_pkg::PRIO_W-1:0]   r_best,     n_best;
    logic                         r_found,    n_found;
    logic [IDX_W-1:0]             r_pick,     n_pick;
    logic [ptd_pkg::ID_W-1:0]     r_pick_id,  n_pick_id;

    // Result staging and the output register.
    ptd_pkg::t_result             r_res, n_res;
    ptd_pkg::t_result             r_out, n_out;

    // Table memory: {priority, id} per slot.
    logic                         ram_we;
    logic [IDX_W-1:0]             ram_waddr;
    logic [ENT_W-1:0]             ram_wdata;
    logic [IDX_W-1:0]             ram_raddr;
    logic [ENT_W-1:0]             ram_rdata;

    logic                         cmd_fire;
    logic                         out_free;
    logic                         issue_more;
    logic [ptd_pkg::PRIO_W-1:0]   ent_prio;
    logic [ptd_pkg::ID_W-1:0]     ent_id;
    logic                         ent_ready;
    ptd_pkg::t_op                 cmd_op;

    ptd_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_TASKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign cmd_op     = ptd_pkg::t_op'(i_cmd.operation);
    assign i_cmd.ready = (r_state == ptd_pkg::S_IDLE);
    assign cmd_fire   = i_cmd.valid && i_cmd.ready;
    assign out_free   = !r_out_valid || o_res.ready;
    assign issue_more = (r_iss < r_used);

    // A create writes the next free slot at the beat it is accepted.
    assign ram_we    = cmd_fire && (cmd_op == ptd_pkg::OP_CREATE) &&
                       (r_used != CNT_W'(MAX_TASKS));
    assign ram_waddr = r_used[IDX_W-1:0];
    assign ram_wdata = {i_cmd.priority_req, i_cmd.task_id};
    assign ram_raddr = r_iss[IDX_W-1:0];

    assign ent_prio = ram_rdata[ENT_W-1 -: ptd_pkg::PRIO_W];
    assign ent_id   = ram_rdata[ptd_pkg::ID_W-1:0];
    // On start, a matching identifier makes the slot ready in the same pass that
    // chooses the task to run, since each slot only affects its own flag.
    assign ent_ready = r_ready[r_pend_idx] || (r_is_start && (ent_id == r_tid));

    always_comb begin
        n_state     = r_state;
        n_ceiling   = r_ceiling;
        n_ready     = r_ready;
        n_used      = r_used;
        n_running   = r_running;
        n_out_valid = r_out_valid;
        n_iss       = r_iss;
        n_pend      = r_pend;
        n_pend_idx  = r_pend_idx;
        n_is_start  = r_is_start;
        n_tid       = r_tid;
        n_best      = r_best;
        n_found     = r_found;
        n_pick      = r_pick;
        n_pick_id   = r_pick_id;
        n_res       = r_res;
        n_out       = r_out;

        if (i_cfg_wr_en) begin
            n_ceiling = i_cfg_wr_data;
        end

        // The output register drains whenever the sink takes the beat.
        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ptd_pkg::S_IDLE: begin
                if (cmd_fire) begin
                    n_iss      = '0;
                    n_pend     = 1'b0;
                    n_is_start = (cmd_op == ptd_pkg::OP_START);
                    n_tid      = i_cmd.task_id;
                    n_best     = r_ceiling;
                    n_found    = 1'b0;
                    n_pick     = '0;
                    n_pick_id  = '0;
                    n_res      = '{status: ptd_pkg::ST_OK, dispatch_valid: 1'b0,
                                   dispatch_slot: '0, dispatch_task_id: '0};
                    case (cmd_op)
                        ptd_pkg::OP_CREATE: begin
                            if (r_used == CNT_W'(MAX_TASKS)) begin
                                n_res.status = ptd_pkg::ST_FULL;
                            end else begin
                                n_ready[r_used[IDX_W-1:0]] = 1'b1;
                                n_used = r_used + CNT_W'(1);
                            end
                            n_state = ptd_pkg::S_FINISH;
                        end
                        ptd_pkg::OP_WAIT: begin
                            n_ready[r_running] = 1'b0;
                            n_state = ptd_pkg::S_SCAN;
                        end
                        default: begin
                            n_state = ptd_pkg::S_SCAN;
                        end
                    endcase
                end
            end

            ptd_pkg::S_SCAN: begin
                if (issue_more) begin
                    n_pend     = 1'b1;
                    n_pend_idx = r_iss[IDX_W-1:0];
                    n_iss      = r_iss + CNT_W'(1);
                end else begin
                    n_pend = 1'b0;
                end

                if (r_pend) begin
                    if (r_is_start && (ent_id == r_tid)) begin
                        n_ready[r_pend_idx] = 1'b1;
                    end
                    // Scanning upward with <= hands ties to the higher slot.
                    if (ent_ready && (ent_prio <= r_best)) begin
                        n_best    = ent_prio;
                        n_found   = 1'b1;
                        n_pick    = r_pend_idx;
                        n_pick_id = ent_id;
                    end
                end

                if (!issue_more && !r_pend) begin
                    if (r_found) begin
                        n_running = r_pick;
                        n_res = '{status: ptd_pkg::ST_OK, dispatch_valid: 1'b1,
                                  dispatch_slot: ptd_pkg::DSLOT_W'(r_pick),
                                  dispatch_task_id: r_pick_id};
                    end else begin
                        n_res = '{status: ptd_pkg::ST_NONE, dispatch_valid: 1'b0,
                                  dispatch_slot: '0, dispatch_task_id: '0};
                    end
                    n_state = ptd_pkg::S_FINISH;
                end
            end

            ptd_pkg::S_FINISH: begin
                // Hold the result until the output register can take it.
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = ptd_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = ptd_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ptd_pkg::S_IDLE;
            r_ceiling   <= ptd_pkg::CEILING_RESET;
            r_ready     <= '0;
            r_used      <= '0;
            r_running   <= '0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ceiling   <= n_ceiling;
            r_ready     <= n_ready;
            r_used      <= n_used;
            r_running   <= n_running;
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
        end
    end

    // Payload and scan bookkeeping registers need no reset.
    always_ff @(posedge i_clk) begin
        r_iss      <= n_iss;
        r_pend_idx <= n_pend_idx;
        r_is_start <= n_is_start;
        r_tid      <= n_tid;
        r_best     <= n_best;
        r_found    <= n_found;
        r_pick     <= n_pick;
        r_pick_id  <= n_pick_id;
        r_res      <= n_res;
        r_out      <= n_out;
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.status           = r_out.status;
    assign o_res.dispatch_valid   = r_out.dispatch_valid;
    assign o_res.dispatch_slot    = r_out.dispatch_slot;
    assign o_res.dispatch_task_id = r_out.dispatch_task_id;

endmodule

// ----- hdl/ptd_checker.sv -----
// Port-level checker for the priority task dispatcher, bound to its top level.
// Depends on ptd_pkg for the status codes.

module ptd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_cmd_valid,
    input logic       i_cmd_ready,
    input logic       i_res_valid,
    input logic       i_res_ready,
    input logic [1:0] i_res_status,
    input logic       i_res_dispatch_valid,
    input logic [2:0] i_res_dispatch_slot,
    input logic [7:0] i_res_dispatch_task_id
);

    // A result beat that is not taken stays offered.
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result beat dropped while stalled");

    // The dispatcher works on one command at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_valid && i_cmd_ready |=> !i_cmd_ready)
        else $error("command accepted while busy");

    // A dispatched task always comes with an ok status.
    a_dispatch_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_dispatch_valid |-> i_res_status == ptd_pkg::ST_OK)
        else $error("dispatch with non-ok status");

    // Without a dispatch, the slot and identifier read as zero.
    a_idle_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_dispatch_valid |->
            i_res_dispatch_slot == 3'd0 && i_res_dispatch_task_id == 8'd0)
        else $error("nonzero dispatch fields without a dispatch");

    // Status never carries the unused code.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> i_res_status == ptd_pkg::ST_OK || i_res_status == ptd_pkg::ST_FULL ||
            i_res_status == ptd_pkg::ST_NONE)
        else $error("undefined status code");

endmodule

bind priority_task_dispatcher ptd_checker u_ptd_checker (
    .i_clk                  (i_clk),
    .i_rst_n                (i_rst_n),
    .i_cmd_valid            (i_cmd.valid),
    .i_cmd_ready            (i_cmd.ready),
    .i_res_valid            (o_res.valid),
    .i_res_ready            (o_res.ready),
    .i_res_status           (o_res.status),
    .i_res_dispatch_valid   (o_res.dispatch_valid),
    .i_res_dispatch_slot    (o_res.dispatch_slot),
    .i_res_dispatch_task_id (o_res.dispatch_task_id)
);
